FILE: rtl/ooo_rob_dispatch_commit_timing_top_macros.svh
// Assertion macros for the dispatch and commit timing block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef OOO_ROB_DISPATCH_COMMIT_TIMING_TOP_MACROS_SVH
`define OOO_ROB_DISPATCH_COMMIT_TIMING_TOP_MACROS_SVH

// The property must hold in the same cycle as its trigger.
`define ORDCT_ASSERT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error(msg);

// The property must hold in the cycle after its trigger.
`define ORDCT_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/ordct_pkg.sv
package ordct_pkg;

  localparam int unsigned ROB_DEPTH         = 64;
  localparam int unsigned FLAG_SLOT         = 8;
  localparam int unsigned NUM_SLOTS         = FLAG_SLOT + 1;
  localparam int unsigned ROB_PTR_W         = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int unsigned CFG_ROB_W         = 7;
  localparam int unsigned ROB_SIZE_W        = (ROB_PTR_W + 1 > CFG_ROB_W) ? ROB_PTR_W + 1
                                                                         : CFG_ROB_W;
  localparam int unsigned ROB_ENTRIES_RESET = 64;
  localparam int unsigned ISSUE_W           = 4;
  localparam int unsigned SLOT_W            = 4;
  localparam int unsigned CYCLE_W           = 32;
  localparam int unsigned CFG_DATA_W        = 7;
  localparam int unsigned REDIRECT_PENALTY  = 2;

  typedef logic [CYCLE_W-1:0] cycle_t;

  typedef enum logic [1:0] {
    CFG_ISSUE_WIDTH = 2'd0,
    CFG_ROB_ENTRIES = 2'd1,
    CFG_IN_ORDER    = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]        source_count;
    logic [SLOT_W-1:0] source_a;
    logic [SLOT_W-1:0] source_b;
    logic [SLOT_W-1:0] source_c;
    logic              writes_register;
    logic [2:0]        dest_register;
    logic              writes_flags;
    logic [4:0]        exec_latency;
    logic              control_penalized;
  } instr_t;

  typedef struct packed {
    cycle_t dispatch_cycle;
    cycle_t execute_cycle;
    cycle_t complete_cycle;
    cycle_t commit_cycle;
  } timing_t;

endpackage

FILE: rtl/ordct_if.sv
interface ordct_instr_if import ordct_pkg::*; ();
  logic   valid;
  logic   ready;
  instr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ordct_timing_if import ordct_pkg::*; ();
  logic    valid;
  logic    ready;
  timing_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ordct_cfg_if import ordct_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_index_e            index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/ooo_rob_dispatch_commit_timing_top.sv
// Channel    Dir  Word                                         Accepted when
// cfg_i      in   index (2 bits), wdata (7 bits)               valid && ready (ready always high)
// instr_i    in   one decoded instruction (instr_t)            valid && ready
// timing_o   out  dispatch, execute, complete, commit cycles   valid && ready
//
// One instruction per clock is sustained while timing_o is taken.
// An accepted instruction is registered in the holding stage, and its result word is then
// registered in the output register, where it is valid: the reorder-buffer memory is read at
// acceptance, and the entry is updated and written back when the held instruction moves on.
// The recurrence through dispatch, execute and commit state sets this rate.
// Reset is asynchronous and clears all control state and the ready table; no
// clearing pass is needed. A stalled output holds one word in flight and the
// instruction channel stays open until a second one waits behind it.
`include "ooo_rob_dispatch_commit_timing_top_macros.svh"

module ooo_rob_dispatch_commit_timing_top import ordct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ordct_cfg_if.sink             cfg_i,
  ordct_instr_if.sink           instr_i,
  ordct_timing_if.source        timing_o
);

  function automatic cycle_t sat_add(cycle_t a, cycle_t b);
    logic [CYCLE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CYCLE_W] ? '1 : s[CYCLE_W-1:0];
  endfunction

  function automatic cycle_t max_cycle(cycle_t a, cycle_t b);
    return (a > b) ? a : b;
  endfunction

  // Configuration registers.
  logic [ISSUE_W-1:0]   issue_width_q;
  logic [CFG_ROB_W-1:0] rob_entries_q;
  logic                 in_order_q;

  // Issue-stage bookkeeping.
  logic [ROB_PTR_W-1:0] rob_ptr_q, rob_ptr_d;
  logic                 rob_filled_q, rob_filled_d;
  cycle_t               slot_q [NUM_SLOTS];

  // Reorder-buffer memory and its registered read.
  cycle_t               rob_mem_q [ROB_DEPTH];
  cycle_t               rob_rd_q;

  // Stage holding one accepted instruction.
  logic                 s1_valid_q, s1_valid_d;
  instr_t               s1_instr_q;
  cycle_t               s1_src_max_q;
  logic                 s1_dep_q;
  logic [ROB_PTR_W-1:0] s1_ptr_q;
  logic                 s1_filled_q;
  logic                 s1_rob_fwd_q;

  // Dispatch, execute and commit state.
  cycle_t               disp_cycle_q, disp_cycle_d;
  logic [ISSUE_W-1:0]   disp_count_q, disp_count_d;
  cycle_t               commit_cycle_q, commit_cycle_d;
  logic [ISSUE_W-1:0]   commit_count_q, commit_count_d;
  cycle_t               fetch_block_q, fetch_block_d;
  cycle_t               prev_exec_q, prev_exec_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  timing_t              timing_q;

  logic                  in_fire, s1_fire, out_free;
  logic [ROB_SIZE_W-1:0] rob_span, ptr_inc;
  logic [ROB_PTR_W-1:0]  ptr_eff;
  logic [NUM_SLOTS-1:0]  slot_hit, slot_kill;
  logic [SLOT_W-1:0]     src [3];
  logic [2:0]            src_used, src_fwd;
  cycle_t                src_val [3];
  cycle_t                src_max;

  logic [ISSUE_W-1:0]    width;
  cycle_t                rob_commit, disp, exec, complete, commit;

  assign out_free        = !out_valid_q || timing_o.ready;
  assign s1_fire         = s1_valid_q && out_free;
  assign instr_i.ready   = !s1_valid_q || s1_fire;
  assign in_fire         = instr_i.valid && instr_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign timing_o.valid  = out_valid_q;
  assign timing_o.data   = timing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_width_q <= ISSUE_W'(1);
      rob_entries_q <= CFG_ROB_W'(ROB_ENTRIES_RESET);
      in_order_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ISSUE_WIDTH: issue_width_q <= cfg_i.wdata[ISSUE_W-1:0];
        CFG_ROB_ENTRIES: rob_entries_q <= cfg_i.wdata[CFG_ROB_W-1:0];
        CFG_IN_ORDER:    in_order_q    <= cfg_i.wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Reorder-buffer pointer, with the configured size clamped to between one and the built depth.
  always_comb begin
    rob_span = ROB_SIZE_W'(rob_entries_q);
    if (rob_entries_q == '0) begin
      rob_span = ROB_SIZE_W'(1);
    end else if (32'(rob_entries_q) > ROB_DEPTH) begin
      rob_span = ROB_SIZE_W'(ROB_DEPTH);
    end
    ptr_eff = (ROB_SIZE_W'(rob_ptr_q) >= rob_span) ? '0 : rob_ptr_q;
    ptr_inc = ROB_SIZE_W'(ptr_eff) + ROB_SIZE_W'(1);
    rob_ptr_d    = rob_ptr_q;
    rob_filled_d = rob_filled_q;
    if (in_fire) begin
      if (ptr_inc >= rob_span) begin
        rob_ptr_d    = '0;
        rob_filled_d = 1'b1;
      end else begin
        rob_ptr_d = ptr_inc[ROB_PTR_W-1:0];
      end
    end
  end

  // Source operand lookup. A slot that the instruction ahead writes in this very
  // cycle is taken instead from that instruction's complete cycle in the output register.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_hit[i] = (s1_instr_q.writes_register &&
                     SLOT_W'(s1_instr_q.dest_register) == SLOT_W'(i)) ||
                    (s1_instr_q.writes_flags && i == FLAG_SLOT);
      slot_kill[i] = s1_fire && slot_hit[i];
    end
    src[0] = instr_i.data.source_a;
    src[1] = instr_i.data.source_b;
    src[2] = instr_i.data.source_c;
    for (int r = 0; r < 3; r++) begin
      src_used[r] = 2'(r) < instr_i.data.source_count;
      src_val[r]  = '0;
      src_fwd[r]  = 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (src_used[r] && src[r] == SLOT_W'(i)) begin
          if (slot_kill[i]) begin
            src_fwd[r] = 1'b1;
          end else begin
            src_val[r] = slot_q[i];
          end
        end
      end
    end
    src_max = max_cycle(max_cycle(src_val[0], src_val[1]), src_val[2]);
  end

  always_comb begin
    width      = (issue_width_q == '0) ? ISSUE_W'(1) : issue_width_q;
    rob_commit = s1_rob_fwd_q ? timing_q.commit_cycle : rob_rd_q;

    disp = (disp_count_q < width) ? disp_cycle_q : sat_add(disp_cycle_q, CYCLE_W'(1));
    disp = max_cycle(disp, fetch_block_q);
    if (s1_filled_q) begin
      disp = max_cycle(disp, sat_add(rob_commit, CYCLE_W'(1)));
    end

    exec = max_cycle(disp, s1_src_max_q);
    if (s1_dep_q) begin
      exec = max_cycle(exec, timing_q.complete_cycle);
    end
    if (in_order_q && exec < prev_exec_q) begin
      exec = prev_exec_q;
    end
    complete = sat_add(exec, CYCLE_W'(s1_instr_q.exec_latency));

    commit = (commit_count_q < width) ? commit_cycle_q
                                      : sat_add(commit_cycle_q, CYCLE_W'(1));
    commit = max_cycle(commit, complete);

    disp_cycle_d   = disp_cycle_q;
    disp_count_d   = disp_count_q;
    commit_cycle_d = commit_cycle_q;
    commit_count_d = commit_count_q;
    fetch_block_d  = fetch_block_q;
    prev_exec_d    = prev_exec_q;
    if (s1_fire) begin
      if (disp == disp_cycle_q && disp_count_q < width) begin
        disp_count_d = disp_count_q + ISSUE_W'(1);
      end else begin
        disp_cycle_d = disp;
        disp_count_d = ISSUE_W'(1);
      end
      if (commit == commit_cycle_q && commit_count_q < width) begin
        commit_count_d = commit_count_q + ISSUE_W'(1);
      end else begin
        commit_cycle_d = commit;
        commit_count_d = ISSUE_W'(1);
      end
      if (s1_instr_q.control_penalized) begin
        fetch_block_d = sat_add(exec, CYCLE_W'(REDIRECT_PENALTY));
      end
      prev_exec_d = exec;
    end

    s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (timing_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rob_ptr_q      <= '0;
      rob_filled_q   <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      disp_cycle_q   <= CYCLE_W'(1);
      disp_count_q   <= '0;
      commit_cycle_q <= CYCLE_W'(1);
      commit_count_q <= '0;
      fetch_block_q  <= '0;
      prev_exec_q    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      rob_ptr_q      <= rob_ptr_d;
      rob_filled_q   <= rob_filled_d;
      s1_valid_q     <= s1_valid_d;
      out_valid_q    <= out_valid_d;
      disp_cycle_q   <= disp_cycle_d;
      disp_count_q   <= disp_count_d;
      commit_cycle_q <= commit_cycle_d;
      commit_count_q <= commit_count_d;
      fetch_block_q  <= fetch_block_d;
      prev_exec_q    <= prev_exec_d;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_kill[i]) begin
          slot_q[i] <= complete;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_instr_q   <= instr_i.data;
      s1_src_max_q <= src_max;
      s1_dep_q     <= |src_fwd;
      s1_ptr_q     <= ptr_eff;
      s1_filled_q  <= rob_filled_q;
      s1_rob_fwd_q <= s1_fire && (s1_ptr_q == ptr_eff);
    end
    if (s1_fire) begin
      timing_q.dispatch_cycle <= disp;
      timing_q.execute_cycle  <= exec;
      timing_q.complete_cycle <= complete;
      timing_q.commit_cycle   <= commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      rob_mem_q[s1_ptr_q] <= commit;
    end
    if (in_fire) begin
      rob_rd_q <= rob_mem_q[ptr_eff];
    end
  end

  `ORDCT_ASSERT(stage_order_a, out_valid_q,
    timing_q.dispatch_cycle <= timing_q.execute_cycle &&
    timing_q.execute_cycle <= timing_q.complete_cycle &&
    timing_q.complete_cycle <= timing_q.commit_cycle,
    "Result cycles are out of order.")
  `ORDCT_ASSERT(in_order_flow_a, s1_fire && out_valid_q,
    disp >= timing_q.dispatch_cycle && commit >= timing_q.commit_cycle,
    "Dispatch or commit went backwards.")
  `ORDCT_ASSERT_NEXT(result_shown_a, s1_fire, timing_o.valid,
    "A finished instruction produced no result word.")

endmodule
